FILE: hdl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  // Fixed field widths of the channels
  localparam int CMD_W  = 4;
  localparam int ARG_W  = 32;
  localparam int ELEM_W = 32;

  // Longest read-out run; later elements of a selection are not emitted
  localparam int RUN_CAP = 16;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT  = 4'd0,
    CMD_ADD_BACK   = 4'd1,
    CMD_DROP_FRONT = 4'd2,
    CMD_DROP_BACK  = 4'd3,
    CMD_CLEAR      = 4'd4,
    CMD_DROP_VALUE = 4'd5,
    CMD_PRINT_ALL  = 4'd6,
    CMD_FIRST_N    = 4'd7,
    CMD_LAST_N     = 4'd8
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/bdq_channels.sv
`default_nettype none

interface bdq_in_if;
  logic                                valid;
  logic                                ready;
  logic        [bdq_pkg::CMD_W-1:0]    cmd;
  logic signed [bdq_pkg::ARG_W-1:0]    argument;

  modport source (output valid, cmd, argument, input ready);
  modport sink   (input valid, cmd, argument, output ready);
endinterface

interface bdq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bdq_pkg::ELEM_W-1:0]   element;
  logic                                has_element;
  logic                                last;

  modport source (output valid, element, has_element, last, input ready);
  modport sink   (input valid, element, has_element, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/bounded_deque_with_value_delete.sv
// Bounded double-ended queue of signed words with delete-by-value.
// Channel req carries one command item (cmd, argument); channel rsp returns
// read-out items (element, has_element, last). Both use valid/ready.
// Add, drop-front, drop-back and clear finish in the cycle they are taken:
// req.ready is high again on the next cycle. Delete-by-value walks the queue
// from the front through the single memory port, reading and comparing each
// entry up to the first match, then moving each later entry one slot toward
// the front to close the gap and dropping the back slot; a miss leaves the
// queue as is. A read-out run addresses each element, then loads the
// registered read data into the output register, at most RUN_CAP elements;
// an empty read-out gives one marker item with has_element low and last high
// once the output register is free.
// req.ready is high only while the sequencer is idle; a finished item may
// still sit in the output register then. If rsp stalls during a run, the
// sequencer holds its place and the pending item stays on rsp.
// Synchronous reset empties the queue (fill and front position to zero) and
// drops any pending output item; the word store itself is not cleared and
// needs no clearing pass.
`default_nettype none

module bounded_deque_with_value_delete #(
  parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  bdq_in_if.sink   req,
  bdq_out_if.source rsp
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH+1);
  localparam int RW    = $clog2(bdq_pkg::RUN_CAP+1);
  localparam int EXT_W = (WORD_BITS > bdq_pkg::ARG_W) ? WORD_BITS : bdq_pkg::ARG_W;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN_RD  = 7'b0000010,
    ST_SCAN_CMP = 7'b0000100,
    ST_SHIFT_RD = 7'b0001000,
    ST_SHIFT_WR = 7'b0010000,
    ST_EMIT_RD  = 7'b0100000,
    ST_EMIT_WR  = 7'b1000000
  } state_t;

  state_t               state;
  logic [AW-1:0]        front;
  logic [CW-1:0]        fill;
  logic [AW-1:0]        pos;
  logic [RW-1:0]        rem;
  logic                 marker;
  logic [WORD_BITS-1:0] key;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data;

  logic                 accept;
  logic                 full;
  logic                 out_free;
  logic [AW-1:0]        front_inc;
  logic [AW-1:0]        front_dec;
  logic [AW-1:0]        addr_off;
  logic [AW-1:0]        addr;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;
  logic                 rd_en;
  logic [WORD_BITS-1:0] arg_word;
  logic [EXT_W-1:0]     arg_ext;
  logic [EXT_W-1:0]     rd_ext;

  logic [AW-1:0]        span_start;
  logic [RW-1:0]        span_count;
  logic                 span_empty;

  // Position of an offset from the front, wrapped around the store
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  bdq_span #(
    .DEPTH (DEPTH)
  ) u_span (
    .cmd   (req.cmd),
    .n     (req.argument),
    .fill  (fill),
    .start (span_start),
    .count (span_count),
    .empty (span_empty)
  );

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (fill == CW'(DEPTH));
  assign out_free  = !rsp.valid || rsp.ready;

  // Narrow the argument to the stored word; widen read data for output
  assign arg_ext  = EXT_W'(req.argument);
  assign arg_word = arg_ext[WORD_BITS-1:0];
  assign rd_ext   = EXT_W'($signed(rd_data));

  assign front_inc = (front == AW'(DEPTH-1)) ? '0 : front + AW'(1);
  assign front_dec = (front == '0) ? AW'(DEPTH-1) : front - AW'(1);

  // Shared address adder: back slot when idle, next entry while reading for a shift, current entry otherwise
  always_comb begin
    case (state)
      ST_IDLE:     addr_off = fill[AW-1:0];
      ST_SHIFT_RD: addr_off = pos + AW'(1);
      default:     addr_off = pos;
    endcase
  end
  assign addr = wrap_add(front, addr_off);

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = rd_data;
    if (state == ST_SHIFT_WR) begin
      wr_en = 1'b1;
    end else if (accept && !full) begin
      if (req.cmd == bdq_pkg::CMD_ADD_FRONT) begin
        wr_en   = 1'b1;
        wr_addr = front_dec;
        wr_data = arg_word;
      end else if (req.cmd == bdq_pkg::CMD_ADD_BACK) begin
        wr_en   = 1'b1;
        wr_data = arg_word;
      end
    end
  end
  assign rd_en = state inside {ST_SCAN_RD, ST_SHIFT_RD, ST_EMIT_RD};

  // Word store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= '0;
      fill      <= '0;
      pos       <= '0;
      rem       <= '0;
      marker    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // Drop the taken item unless a new one is loaded below
      if (rsp.ready && !((state == ST_EMIT_WR) && out_free)) rsp.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.cmd)
              bdq_pkg::CMD_ADD_FRONT: begin
                if (!full) begin
                  front <= front_dec;
                  fill  <= fill + CW'(1);
                end
              end
              bdq_pkg::CMD_ADD_BACK: begin
                if (!full) fill <= fill + CW'(1);
              end
              bdq_pkg::CMD_DROP_FRONT: begin
                if (fill != '0) begin
                  front <= front_inc;
                  fill  <= fill - CW'(1);
                end
              end
              bdq_pkg::CMD_DROP_BACK: begin
                if (fill != '0) fill <= fill - CW'(1);
              end
              bdq_pkg::CMD_CLEAR: begin
                fill <= '0;
              end
              bdq_pkg::CMD_DROP_VALUE: begin
                key <= arg_word;
                pos <= '0;
                if (fill != '0) state <= ST_SCAN_RD;
              end
              bdq_pkg::CMD_PRINT_ALL, bdq_pkg::CMD_FIRST_N, bdq_pkg::CMD_LAST_N: begin
                pos    <= span_start;
                rem    <= span_count;
                marker <= span_empty;
                state  <= span_empty ? ST_EMIT_WR : ST_EMIT_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          // Stop at the first match, or give up at the back end
          if (rd_data == key) begin
            state <= ST_SHIFT_RD;
          end else if (CW'(pos) + CW'(1) == fill) begin
            state <= ST_IDLE;
          end else begin
            pos   <= pos + AW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_SHIFT_RD: begin
          // Close the gap one entry at a time, then drop the back slot
          if (CW'(pos) + CW'(1) >= fill) begin
            fill  <= fill - CW'(1);
            state <= ST_IDLE;
          end else begin
            state <= ST_SHIFT_WR;
          end
        end
        ST_SHIFT_WR: begin
          pos   <= pos + AW'(1);
          state <= ST_SHIFT_RD;
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_WR;
        end
        ST_EMIT_WR: begin
          // Load the output register once it is free
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.element     <= marker ? '0 : rd_ext[bdq_pkg::ELEM_W-1:0];
            rsp.has_element <= !marker;
            rsp.last        <= marker || (rem == RW'(1));
            if (marker || (rem == RW'(1))) begin
              state <= ST_IDLE;
            end else begin
              rem   <= rem - RW'(1);
              pos   <= pos + AW'(1);
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Fill never passes the capacity
  assert property (@(posedge clk) disable iff (rst) fill <= CW'(DEPTH))
    else $error("fill count above capacity");

  // Fill moves by at most one per cycle, except for a clear
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fill == $past(fill)) || (fill == $past(fill) + CW'(1)) ||
                    (fill == $past(fill) - CW'(1)) || (fill == '0))
    else $error("fill count jumped");

  // A run in progress always has elements left to emit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_WR) || (state == ST_EMIT_RD) |-> marker || (rem != '0))
    else $error("read-out run with no elements left");

  // Printing a non-empty queue never yields the empty marker
  assert property (@(posedge clk) disable iff (rst)
    accept && (req.cmd == bdq_pkg::CMD_PRINT_ALL) && (fill != '0) |=> !marker)
    else $error("marker emitted for non-empty queue");

endmodule

`default_nettype wire

FILE: hdl/bdq_span.sv
`default_nettype none

// Work out which stretch of the queue a read-out command covers:
// offset of its first element from the front and its capped length.
module bdq_span #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic        [bdq_pkg::CMD_W-1:0]                cmd,
  input  wire logic signed [bdq_pkg::ARG_W-1:0]                n,
  input  wire logic        [$clog2(DEPTH+1)-1:0]               fill,
  output      logic        [$clog2(DEPTH)-1:0]                 start,
  output      logic        [$clog2(bdq_pkg::RUN_CAP+1)-1:0]    count,
  output      logic                                            empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int RW = $clog2(bdq_pkg::RUN_CAP+1);
  localparam int MW = (CW > RW) ? CW : RW;

  logic          n_none;
  logic          n_below;
  logic [CW-1:0] full_cnt;
  logic [CW-1:0] first_ofs;

  // Classify the requested count against the fill
  assign n_none  = n[bdq_pkg::ARG_W-1] || (n == '0);
  assign n_below = !n[bdq_pkg::ARG_W-1] &&
                   ($unsigned(n) < bdq_pkg::ARG_W'(fill));

  // Select the length before the run cap
  always_comb begin
    full_cnt  = fill;
    first_ofs = '0;
    case (cmd)
      bdq_pkg::CMD_FIRST_N: begin
        if (n_none) full_cnt = '0;
        else if (n_below) full_cnt = n[CW-1:0];
        else full_cnt = fill;
      end
      bdq_pkg::CMD_LAST_N: begin
        if (n_none || !n_below) full_cnt = fill;
        else full_cnt = n[CW-1:0];
        first_ofs = fill - full_cnt;
      end
      default: begin
        full_cnt  = fill;
        first_ofs = '0;
      end
    endcase
  end

  // Keep the front-most elements when the run is too long
  assign start = first_ofs[AW-1:0];
  assign empty = (full_cnt == '0);
  assign count = (MW'(full_cnt) > MW'(bdq_pkg::RUN_CAP)) ? RW'(bdq_pkg::RUN_CAP)
                                                         : RW'(full_cnt);

endmodule

`default_nettype wire
